### design/rsog_pkg.sv
// ---------------------------------------------------------------------------
// rsog_pkg: shared constants for the ring sample offset generator
// Register indexes, divider and CORDIC constants, arctangent step table.
// ---------------------------------------------------------------------------
`default_nettype none

package rsog_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgRadius     = 2'd0;
  localparam logic [1:0] CfgPointCount = 2'd1;
  localparam logic [1:0] CfgRingCount  = 2'd2;

  // Field widths fixed by the interface
  localparam int RadiusW = 16;
  localparam int CountW  = 13;
  localparam int PointW  = 12;
  localparam int OffsetW = 17;

  // Quotient bits produced by the shared divider (both divisions fit in 17)
  localparam int DivSteps = 17;

  // CORDIC constants: gain compensation in Q2.30, table depth
  localparam int                 CordicMaxSteps = 24;
  localparam logic signed [33:0] KinvQ30        = 34'sd652032874;
  localparam logic signed [33:0] QuarterTurn    = 34'sd1073741824;

  // Rounding constant and saturation limit of the final scaling
  localparam logic [47:0] RoundHalf = 48'd536870912;
  localparam logic [17:0] OffMax    = 18'd65535;

  // Arctangent of 2^-i in 2^-32 turn units, padded with zeros to 32 entries
  localparam logic [31:0] AtanTurns [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd0,         32'd0,         32'd0,         32'd0,
    32'd0,         32'd0,         32'd0,         32'd0
  };

endpackage

`default_nettype wire

### design/ring_sample_offset_generator.sv
// ---------------------------------------------------------------------------
// ring_sample_offset_generator: concentric-ring sample offset sequencer
// Emits one Q8.8 offset per request word: the center, then every point of
// every ring, computed with a shared divider, multiplier and CORDIC.
// ---------------------------------------------------------------------------
//
//  Channel  | Signals                                    | Dir | Handshake
//  ---------+--------------------------------------------+-----+----------------
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i            | in  | write on we
//  request  | in_valid_i, in_ready_o, restart_i          | in  | valid / ready
//  result   | out_valid_o, out_ready_i, offset_x_o,      | out | valid / ready
//           | offset_y_o, ring_number_o, last_o          |     |
//
//  Flow: a center word goes from accept straight to the output state. A ring
//  point runs the multiplier states, the bit-serial divider (two divisions of
//  17 quotient bits each), the CORDIC loop and the scaling states.
//  Reset: no clearing pass; the first word after reset is the center.
//  Stalls: the request side is ready only between words; a finished word
//  waits in the output register while the next request is taken.
//
`default_nettype none

module ring_sample_offset_generator #(
  parameter int MAX_COUNT    = 4096,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [rsog_pkg::RadiusW-1:0]  cfg_data_i,
  // request channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          restart_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [rsog_pkg::OffsetW-1:0] offset_x_o,
  output logic signed [rsog_pkg::OffsetW-1:0] offset_y_o,
  output logic [rsog_pkg::CountW-1:0]        ring_number_o,
  output logic                               last_o
);

  import rsog_pkg::*;

  // Iterations actually run: the arctangent table stops at 24 steps
  localparam int CordicIter = (CORDIC_STEPS < CordicMaxSteps) ? CORDIC_STEPS
                                                              : CordicMaxSteps;

  typedef enum logic [3:0] {
    S_IDLE,
    S_M0,      // radius * ring
    S_M1,      // load ring-radius division, k * R
    S_M2,      // angle numerator, P * R
    S_M3,      // angle denominator
    S_DIV_RR,  // ring radius division
    S_LD_A,    // load angle division
    S_DIV_A,   // angle division
    S_CPREP,   // fold angle into +-1/4 turn, seed CORDIC
    S_CORDIC,  // CORDIC rotations
    S_MX,      // rr * cos
    S_MY,      // scale x, rr * sin
    S_SY,      // scale y
    S_OUT      // hand word to output register
  } state_e;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic [RadiusW-1:0] radius_q;
  logic [CountW-1:0]  point_count_q;
  logic [CountW-1:0]  ring_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q      <= '0;
      point_count_q <= CountW'(1);
      ring_count_q  <= CountW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRadius:     radius_q      <= cfg_data_i;
        CfgPointCount: point_count_q <= cfg_data_i[CountW-1:0];
        CfgRingCount:  ring_count_q  <= cfg_data_i[CountW-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer state and registered outputs
  // -------------------------------------------------------------------------
  state_e              state_q;
  logic [4:0]          cnt_q;
  logic [CountW-1:0]   ring_cnt_q;
  logic [PointW-1:0]   pt_cnt_q;
  logic                out_valid_q;
  logic signed [OffsetW-1:0] out_x_q;
  logic signed [OffsetW-1:0] out_y_q;
  logic [CountW-1:0]   out_ring_q;
  logic                out_last_q;

  // Datapath registers
  logic signed [48:0]  mul_q;
  logic [24:0]         rem_q;
  logic [DivSteps-1:0] low_q;
  logic [24:0]         dvs_q;
  logic [23:0]         num_q;
  logic [24:0]         den_q;
  logic [RadiusW-1:0]  rr_q;
  logic signed [33:0]  x_q;
  logic signed [33:0]  y_q;
  logic signed [33:0]  z_q;
  logic                flip_q;
  logic signed [OffsetW-1:0] res_x_q;
  logic signed [OffsetW-1:0] res_y_q;
  logic [CountW-1:0]   ring_w_q;
  logic [PointW-1:0]   k_w_q;
  logic                fin_q;

  // -------------------------------------------------------------------------
  // Request decode: config check, stale-state check, end of pattern
  // -------------------------------------------------------------------------
  logic              in_acc;
  logic              cfg_ok;
  logic              to_center;
  logic              pt_fin;
  logic [CountW-1:0] pt_next;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    cfg_ok = (radius_q != '0)
          && (point_count_q != '0) && (point_count_q <= CountW'(MAX_COUNT))
          && (ring_count_q != '0)  && (ring_count_q <= CountW'(MAX_COUNT));
    // Restart, a fresh pattern or a counter left stale by a config change
    to_center = restart_i || (ring_cnt_q == '0) || (ring_cnt_q > ring_count_q)
             || ({1'b0, pt_cnt_q} >= point_count_q);
    pt_next = {1'b0, pt_cnt_q} + CountW'(1);
    pt_fin  = (ring_cnt_q == ring_count_q) && (pt_next == point_count_q);
  end

  // -------------------------------------------------------------------------
  // Shared multiplier: operands steered by the sequencer
  // -------------------------------------------------------------------------
  logic signed [16:0] mul_a;
  logic signed [31:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_M0: begin
        mul_a = {1'b0, radius_q};
        mul_b = {19'b0, ring_w_q};
      end
      S_M1: begin
        mul_a = {5'b0, k_w_q};
        mul_b = {19'b0, ring_count_q};
      end
      S_M2: begin
        mul_a = {4'b0, point_count_q};
        mul_b = {19'b0, ring_count_q};
      end
      S_MX: begin
        mul_a = {1'b0, rr_q};
        mul_b = x_q[31:0];
      end
      S_MY: begin
        mul_a = {1'b0, rr_q};
        mul_b = y_q[31:0];
      end
      default: ;
    endcase
  end

  // -------------------------------------------------------------------------
  // Shared restoring divider step: one quotient bit per cycle
  // -------------------------------------------------------------------------
  logic [25:0] div_shift;
  logic [26:0] div_diff;
  logic        div_ge;
  logic [28:0] rr_dvd;
  logic [40:0] ang_dvd;

  always_comb begin
    div_shift = {rem_q, low_q[DivSteps-1]};
    div_diff  = {1'b0, div_shift} - {2'b0, dvs_q};
    div_ge    = !div_diff[26];
    // Round to nearest: add half the divisor up front
    rr_dvd    = 29'(mul_q[27:0]) + 29'(ring_count_q[CountW-1:1]);
    ang_dvd   = 41'({num_q, 16'b0}) + 41'(den_q[24:1]);
  end

  // -------------------------------------------------------------------------
  // CORDIC rotation step (shifts are arithmetic, rounding toward -inf)
  // -------------------------------------------------------------------------
  logic signed [33:0] cor_dx;
  logic signed [33:0] cor_dy;
  logic signed [33:0] cor_at;
  logic [15:0]        a16;
  logic               a_flip;

  always_comb begin
    cor_dx = y_q >>> cnt_q;
    cor_dy = x_q >>> cnt_q;
    cor_at = $signed({2'b0, AtanTurns[cnt_q]});
    a16    = low_q[15:0];  // quotient modulo one turn
    // Angle in [1/4, 3/4) turn: rotate by half a turn and negate at the end
    a_flip = a16[15] ^ a16[14];
  end

  // -------------------------------------------------------------------------
  // Final scaling: sign-magnitude round, saturate, apply half-turn flip
  // -------------------------------------------------------------------------
  logic               sc_neg;
  logic [48:0]        sc_mag;
  logic [47:0]        sc_rnd;
  logic [17:0]        sc_q;
  logic [16:0]        sc_sat;
  logic signed [16:0] scaled;

  always_comb begin
    sc_neg = mul_q[48];
    sc_mag = sc_neg ? 49'(-mul_q) : 49'(mul_q);
    sc_rnd = sc_mag[47:0] + RoundHalf;
    sc_q   = sc_rnd[47:30];
    sc_sat = (sc_q > OffMax) ? OffMax[16:0] : sc_q[16:0];
    scaled = (sc_neg ^ flip_q) ? -$signed(sc_sat) : $signed(sc_sat);
  end

  // -------------------------------------------------------------------------
  // Sequencer: state, counters and output register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ring_cnt_q  <= '0;
      pt_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_ring_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // Drop a taken word, unless S_OUT refills the register this cycle
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (!cfg_ok) begin
              ring_cnt_q <= '0;
              pt_cnt_q   <= '0;
              state_q    <= S_OUT;
            end else if (to_center) begin
              ring_cnt_q <= CountW'(1);
              pt_cnt_q   <= '0;
              state_q    <= S_OUT;
            end else begin
              // Advance the pattern now; this word's ring and point are held
              if (pt_fin) begin
                ring_cnt_q <= '0;
                pt_cnt_q   <= '0;
              end else if (pt_next >= point_count_q) begin
                ring_cnt_q <= ring_cnt_q + CountW'(1);
                pt_cnt_q   <= '0;
              end else begin
                pt_cnt_q   <= pt_next[PointW-1:0];
              end
              state_q <= S_M0;
            end
          end
        end
        S_M0: state_q <= S_M1;
        S_M1: state_q <= S_M2;
        S_M2: state_q <= S_M3;
        S_M3: begin
          cnt_q   <= '0;
          state_q <= S_DIV_RR;
        end
        S_DIV_RR: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(DivSteps - 1)) begin
            state_q <= S_LD_A;
          end
        end
        S_LD_A: begin
          cnt_q   <= '0;
          state_q <= S_DIV_A;
        end
        S_DIV_A: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(DivSteps - 1)) begin
            state_q <= S_CPREP;
          end
        end
        S_CPREP: begin
          cnt_q   <= '0;
          state_q <= S_CORDIC;
        end
        S_CORDIC: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(CordicIter - 1)) begin
            state_q <= S_MX;
          end
        end
        S_MX: state_q <= S_MY;
        S_MY: state_q <= S_SY;
        S_SY: state_q <= S_OUT;
        S_OUT: begin
          // Hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_x_q     <= res_x_q;
            out_y_q     <= res_y_q;
            out_ring_q  <= ring_w_q;
            out_last_q  <= fin_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Datapath registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_x_q  <= '0;
          res_y_q  <= '0;
          k_w_q    <= pt_cnt_q;
          if (!cfg_ok) begin
            ring_w_q <= '0;
            fin_q    <= 1'b1;
          end else if (to_center) begin
            ring_w_q <= '0;
            fin_q    <= 1'b0;
          end else begin
            ring_w_q <= ring_cnt_q;
            fin_q    <= pt_fin;
          end
        end
      end
      S_M1: begin
        rem_q <= 25'(rr_dvd[28:DivSteps]);
        low_q <= rr_dvd[DivSteps-1:0];
        dvs_q <= 25'(ring_count_q);
      end
      S_M2: num_q <= mul_q[23:0] + 24'(ring_w_q - CountW'(1));
      S_M3: den_q <= mul_q[24:0];
      S_DIV_RR, S_DIV_A: begin
        rem_q <= div_ge ? div_diff[24:0] : div_shift[24:0];
        low_q <= {low_q[DivSteps-2:0], div_ge};
      end
      S_LD_A: begin
        rr_q  <= low_q[RadiusW-1:0];
        rem_q <= 25'(ang_dvd[40:DivSteps]);
        low_q <= ang_dvd[DivSteps-1:0];
        dvs_q <= den_q;
      end
      S_CPREP: begin
        flip_q <= a_flip;
        z_q    <= $signed({{2{a16[15] ^ a_flip}}, a16[15] ^ a_flip, a16[14:0], 16'b0});
        x_q    <= KinvQ30;
        y_q    <= '0;
      end
      S_CORDIC: begin
        if (z_q[33]) begin
          x_q <= x_q + cor_dx;
          y_q <= y_q - cor_dy;
          z_q <= z_q + cor_at;
        end else begin
          x_q <= x_q - cor_dx;
          y_q <= y_q + cor_dy;
          z_q <= z_q - cor_at;
        end
      end
      S_MY: res_x_q <= scaled;
      S_SY: res_y_q <= scaled;
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign offset_x_o    = out_x_q;
  assign offset_y_o    = out_y_q;
  assign ring_number_o = out_ring_q;
  assign last_o        = out_last_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  // A taken request always moves the sequencer out of idle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("request taken but sequencer stayed idle");

  // Divider remainder stays below the divisor for every quotient step
  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_RR || state_q == S_DIV_A) |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

  // Folded angle lies within a quarter turn when rotations begin
  a_cordic_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CORDIC && cnt_q == '0) |-> (z_q <= QuarterTurn && z_q >= -QuarterTurn))
    else $error("CORDIC seed angle out of range");

  // The center word carries a zero offset
  a_center_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ring_number_o == '0) |-> (offset_x_o == '0 && offset_y_o == '0))
    else $error("center word with nonzero offset");

endmodule

`default_nettype wire

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the ring sample offset generator
// Feeds request words, with and without restart, through a series of
// register settings (valid, invalid, stale and extreme), predicts each
// offset word with an independent fixed-point CORDIC model, and checks
// every result word under random stalls on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  import rsog_pkg::*;

  localparam int      MaxCount    = 4096;
  localparam int      CordicSteps = 16;
  localparam int      RandomWords = 1350;
  localparam int      StallLimit  = 4000;
  localparam int      SettlePad   = 100;
  localparam longint  Kinv        = 64'sd652032874;
  localparam longint  HalfTurn    = 64'sh8000_0000;
  localparam longint  FullTurn    = 64'sh1_0000_0000;
  localparam longint  QuarterLo   = 64'sh4000_0000;
  localparam longint  QuarterHi   = 64'shC000_0000;
  localparam longint  Mask32      = 64'shFFFF_FFFF;
  localparam longint  OffLimit    = 64'sd65535;

  // arctangent of 2^-i in 2^-32 turn units
  localparam longint AtanStep [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    logic signed [OffsetW-1:0] ox;
    logic signed [OffsetW-1:0] oy;
    logic [CountW-1:0]         ring;
    logic                      last;
  } offset_word_t;

  // DUT inputs, all known from time zero
  logic                     clk_i       = 1'b1;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [1:0]               cfg_idx_i   = CfgRadius;
  logic [RadiusW-1:0]       cfg_data_i  = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     restart_i   = 1'b0;
  logic                     out_ready_i = 1'b0;

  logic                      in_ready_o;
  logic                      out_valid_o;
  logic signed [OffsetW-1:0] offset_x_o;
  logic signed [OffsetW-1:0] offset_y_o;
  logic [CountW-1:0]         ring_number_o;
  logic                      last_o;

  ring_sample_offset_generator #(
    .MAX_COUNT   (MaxCount),
    .CORDIC_STEPS(CordicSteps)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .offset_x_o   (offset_x_o),
    .offset_y_o   (offset_y_o),
    .ring_number_o(ring_number_o),
    .last_o       (last_o)
  );

  // 4 ns period
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Shadow copy of the registers and the sequence position
  longint radius_sh  = 0;
  longint points_sh  = 1;
  longint rings_sh   = 1;
  longint ring_pos   = 0;
  longint point_pos  = 0;

  bit           restart_q [$];     // request words waiting to be driven
  offset_word_t offsets_due [$];   // predicted result words, oldest first
  bit           word_taken   = 1'b0;
  bit           tx_gaps_on   = 1'b1;
  bit           rx_gaps_on   = 1'b1;
  int           tx_gap_left  = 0;
  int           rx_stall_left = 0;
  int           mismatches   = 0;
  int           idle_cycles  = 0;
  int           random_sent  = 0;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Scale a Q2.30 unit component by the ring radius: round half away
  // from zero, then clamp the magnitude.
  function automatic longint scale_offset(input longint rr, input longint c);
    longint prod, mag, q;
    prod = rr * c;
    mag  = (prod < 0) ? -prod : prod;
    q    = (mag + (64'sd1 <<< 29)) >>> 30;
    if (q > OffLimit) q = OffLimit;
    return (prod < 0) ? -q : q;
  endfunction

  // Fold the angle into +-1/4 turn, rotate the gain-compensated unit
  // vector, unfold, and scale both components.
  task automatic polar_offset(input longint rr, input longint a16,
                              output longint ox, output longint oy);
    longint ang, x, y, z, dx, dy;
    bit     flip;
    ang  = (a16 & 64'shFFFF) <<< 16;
    flip = 1'b0;
    if (ang >= QuarterLo && ang < QuarterHi) begin
      ang  = (ang - HalfTurn) & Mask32;
      flip = 1'b1;
    end
    z = (ang < HalfTurn) ? ang : ang - FullTurn;
    x = Kinv;
    y = 0;
    for (int i = 0; i < CordicSteps && i < 24; i++) begin
      // arithmetic shift of a signed value rounds toward minus infinity
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - AtanStep[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + AtanStep[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    ox = scale_offset(rr, x);
    oy = scale_offset(rr, y);
  endtask

  // Predict the word for one accepted request and advance the position
  task automatic next_offset(input bit restart, output offset_word_t w);
    longint p, r, ring, k, rr, num, den, a16, ox, oy;
    bit     cfg_ok, fin;
    w.ox   = '0;
    w.oy   = '0;
    w.ring = '0;
    w.last = 1'b0;
    p = points_sh;
    r = rings_sh;
    cfg_ok = radius_sh != 0 && p >= 1 && p <= MaxCount && r >= 1 && r <= MaxCount;
    if (!cfg_ok) begin
      // unusable settings: center only, always marked last
      ring_pos  = 0;
      point_pos = 0;
      w.last    = 1'b1;
    end else if (restart || ring_pos == 0 || ring_pos > r || point_pos >= p) begin
      // restart, start of pattern, or position left stale by new settings
      ring_pos  = 1;
      point_pos = 0;
    end else begin
      ring = ring_pos;
      k    = point_pos;
      rr   = (radius_sh * ring + r / 2) / r;
      num  = (ring - 1) + k * r;
      den  = p * r;
      a16  = ((num <<< 16) + den / 2) / den;
      fin  = (ring == r) && (k == p - 1);
      polar_offset(rr, a16, ox, oy);
      w.ox   = ox[OffsetW-1:0];
      w.oy   = oy[OffsetW-1:0];
      w.ring = ring[CountW-1:0];
      w.last = fin;
      if (fin) begin
        ring_pos  = 0;
        point_pos = 0;
      end else if (k + 1 >= p) begin
        ring_pos  = ring + 1;
        point_pos = 0;
      end else begin
        point_pos = k + 1;
      end
    end
  endtask

  // Request driver: change at the falling edge, hold valid until taken
  always @(negedge clk_i) begin
    logic nxt_valid;
    logic nxt_restart;
    nxt_valid   = in_valid_i;
    nxt_restart = restart_i;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else begin
      if (word_taken) begin
        nxt_valid  = 1'b0;
        word_taken = 1'b0;
      end
      if (!nxt_valid) begin
        nxt_restart = 1'($urandom_range(0, 1));  // noise while idle
        if (tx_gap_left > 0) begin
          tx_gap_left--;
        end else if (restart_q.size() > 0) begin
          nxt_restart = restart_q.pop_front();
          nxt_valid   = 1'b1;
          tx_gap_left = tx_gaps_on ? pick_gap() : 0;
        end
      end
    end
    in_valid_i <= nxt_valid;
    restart_i  <= nxt_restart;
  end

  // Result receiver: random back-pressure
  always @(negedge clk_i) begin
    int stall;
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      stall = rx_gaps_on ? pick_gap() : 0;
      if (stall > 0) begin
        rx_stall_left = stall - 1;
        out_ready_i   <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    offset_word_t w;
    offset_word_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        next_offset(restart_i, w);
        offsets_due.push_back(w);
        word_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        if (offsets_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: x=%0d y=%0d ring=%0d last=%0b",
                     offset_x_o, offset_y_o, ring_number_o, last_o);
        end else begin
          want = offsets_due.pop_front();
          if (offset_x_o !== want.ox || offset_y_o !== want.oy ||
              ring_number_o !== want.ring || last_o !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: want x=%0d y=%0d ring=%0d last=%0b,",
                       want.ox, want.oy, want.ring, want.last,
                       " got x=%0d y=%0d ring=%0d last=%0b",
                       offset_x_o, offset_y_o, ring_number_o, last_o);
          end
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold the sender until every queued word is sent and every result is in
  task automatic drain();
    while (restart_q.size() != 0 || in_valid_i || offsets_due.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write all three registers back to back; only called while idle
  task automatic set_config(input logic [15:0] rad, input logic [15:0] pts,
                            input logic [15:0] rng);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgRadius;
    cfg_data_i <= rad;
    radius_sh  = longint'(rad);
    @(negedge clk_i);
    cfg_idx_i  <= CfgPointCount;
    cfg_data_i <= pts;
    points_sh  = longint'(pts & 16'h1FFF);
    @(negedge clk_i);
    cfg_idx_i  <= CfgRingCount;
    cfg_data_i <= rng;
    rings_sh   = longint'(rng & 16'h1FFF);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic push_words(input int n, input int restart_pct);
    for (int i = 0; i < n; i++)
      restart_q.push_back($urandom_range(0, 99) < restart_pct);
  endtask

  initial begin
    int sel, n;
    logic [15:0] rad, pts, rng;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset settings are unusable (radius zero), center only
    restart_q.push_back(1'b1);
    restart_q.push_back(1'b0);
    drain();

    // Largest radius, one point: center, saturating point marked last,
    // wrap to center, restart, point again
    set_config(16'hFFFF, 16'd1, 16'd1);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b1);
    restart_q.push_back(1'b0);
    drain();

    // Smallest radius, walk into ring 2, then shrink the point count so
    // the stored position goes stale
    set_config(16'd1, 16'd2, 16'd3);
    push_words(4, 0);
    drain();
    set_config(16'd1, 16'd1, 16'd3);
    push_words(2, 0);
    drain();

    // Largest counts
    set_config(16'h0100, 16'd4096, 16'd4096);
    push_words(3, 0);
    drain();

    // Zero points, zero rings, point count beyond the limit
    set_config(16'h1234, 16'd0, 16'd2);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b1);
    drain();
    set_config(16'h1234, 16'd3, 16'd0);
    push_words(1, 0);
    drain();
    set_config(16'h1234, 16'd8191, 16'd1);
    push_words(1, 0);
    drain();

    // Four points on one ring: angles on every quadrant boundary
    set_config(16'h8000, 16'd4, 16'd1);
    push_words(5, 0);
    drain();

    // Random phases; each phase boundary drains the block fully
    while (random_sent < RandomWords) begin
      tx_gaps_on = $urandom_range(0, 3) != 0;
      rx_gaps_on = $urandom_range(0, 3) != 0;
      sel = $urandom_range(0, 99);
      rad = 16'($urandom_range(1, 16'hFFFF));
      if ($urandom_range(0, 9) == 0) rad = 16'hFFFF;
      if ($urandom_range(0, 9) == 0) rad = 16'd1;
      if (sel < 70) begin
        pts = 16'($urandom_range(1, 6));
        rng = 16'($urandom_range(1, 4));
        n   = (pts * rng + 1) * $urandom_range(1, 3) + $urandom_range(0, 3);
      end else if (sel < 80) begin
        pts = 16'($urandom_range(1, 64));
        rng = 16'($urandom_range(1, 8));
        n   = $urandom_range(10, 60);
      end else if (sel < 86) begin
        pts = 16'($urandom_range(1, MaxCount));
        rng = 16'($urandom_range(1, MaxCount));
        n   = $urandom_range(5, 30);
      end else if (sel < 94) begin
        pts = 16'($urandom_range(1, 6));
        rng = 16'($urandom_range(1, 4));
        case ($urandom_range(0, 4))
          0:       rad = 16'd0;
          1:       pts = 16'd0;
          2:       rng = 16'd0;
          3:       pts = 16'($urandom_range(MaxCount + 1, 8191));
          default: rng = 16'($urandom_range(MaxCount + 1, 8191));
        endcase
        n = $urandom_range(3, 10);
      end else begin
        // full-width register data; upper bits of the counts are dropped
        rad = 16'($urandom);
        pts = 16'($urandom);
        rng = 16'($urandom);
        n   = $urandom_range(3, 15);
      end
      if (n > 60) n = 60;
      set_config(rad, pts, rng);
      push_words(n, ($urandom_range(0, 3) == 0) ? 20 : 3);
      random_sent += n;
      drain();
    end

    repeat (SettlePad) @(posedge clk_i);
    if (mismatches == 0 && offsets_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
design/rsog_pkg.sv
design/ring_sample_offset_generator.sv
tb/tb_top.sv
